// ----- hdl/ssas_pkg.sv -----
// Shared types and constants of the sonar scan angle sequencer.
package ssas_pkg;

   localparam int GRADS_PER_TURN = 400;
   localparam int HALF_TURN      = 200;
   localparam int MAX_DEG        = 360;
   localparam int NO_FIT_COST    = 1000;
   localparam int FIT_SPAN       = 10;

   // floor(n / d) == (n * RECIP) >> RECIP_SHIFT for every numerator in use
   localparam int RECIP_SHIFT    = 27;
   localparam logic [23:0] RECIP_360 = 24'd372828;
   localparam logic [23:0] RECIP_10  = 24'd13421773;

   typedef enum logic {
      OP_CONFIGURE = 1'b0,
      OP_ADVANCE   = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      DIV_BY_360,
      DIV_BY_10
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CFG_TH,
      ST_CFG_TS,
      ST_MOD,
      ST_CHK,
      ST_NEXT_S,
      ST_SRCH,
      ST_SET,
      ST_RANGE,
      ST_HEAD,
      ST_ADV_ADD,
      ST_ADV_TEST,
      ST_FIN_AP,
      ST_FIN_ST
   } state_type;

endpackage

// ----- hdl/ssas_const_div.sv -----
// Shared divide-by-constant unit: quotient by 360 or 10 through a reciprocal multiply.
module ssas_const_div (
   input  logic [17:0]          num,
   input  ssas_pkg::div_sel_type sel,
   output logic [8:0]           quot
);

   logic [23:0] recip;
   logic [41:0] prod;

   always_comb begin
      case (sel)
         ssas_pkg::DIV_BY_360: recip = ssas_pkg::RECIP_360;
         ssas_pkg::DIV_BY_10:  recip = ssas_pkg::RECIP_10;
         default:              recip = ssas_pkg::RECIP_10;
      endcase
   end

   assign prod = {24'd0, num} * {18'd0, recip};
   assign quot = prod[ssas_pkg::RECIP_SHIFT +: 9];

endmodule

// ----- hdl/sonar_scan_angle_sequencer.sv -----
// Top level of the sonar scan angle sequencer: command port, sequencer and datapath.
//
// Usage: drive req_op and the req_ fields and raise start; the beat is taken
// at a rising edge with start high and busy low. busy stays high until the
// result is out. Every beat gives exactly one result on the rsp_ ports,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// An advance beat (req_op = 1) goes from accept to rsp_valid through:
// add step, boundary test, then two passes through the shared constant
// divider that rounds aperture and step back to degrees.
// A configure beat skips the head grid check when the head falls outside
// the new limits, else runs it as a remainder loop by the step.
// Fitting adds the remainder of the half aperture by the step (one subtract
// per cycle) and a check state; if that remainder is nonzero the search runs
// up to 799 candidate steps, each with a setup state, its own remainder loop
// and up to 11 half-aperture values (one per cycle).
// One reciprocal multiplier does all of the divisions by 360 and 10.
// Reset (synchronous, active high) gives a full circle with step 1 grad,
// head angle 0, and no pending result.
module sonar_scan_angle_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_op,
   input  logic [8:0] req_aperture,
   input  logic [8:0] req_step,
   input  logic       req_fit_divisor,
   output logic       rsp_valid,
   output logic [8:0] rsp_angle_grad,
   output logic       rsp_end_of_turn,
   output logic [8:0] rsp_actual_aperture,
   output logic [8:0] rsp_actual_step
);

   ssas_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic signed [10:0] head_ff, head_in;
   logic signed [9:0]  step_ff, step_in;
   logic signed [8:0]  low_ff, low_in;
   logic signed [8:0]  high_ff, high_in;

   logic [8:0] ap_ff, ap_in;
   logic [8:0] st_ff, st_in;
   logic       fit_ff, fit_in;
   logic [7:0] th_ff, th_in;
   logic [8:0] ts_ff, ts_in;
   logic [9:0] bs_ff, bs_in;
   logic [7:0] bh_ff, bh_in;
   logic [9:0] best_ff, best_in;
   logic [9:0] s_ff, s_in;
   logic [7:0] h_ff, h_in;
   logic [3:0] hd_ff, hd_in;
   logic [8:0] sd_ff, sd_in;
   logic [8:0] rem_ff, rem_in;
   logic [9:0] div_ff, div_in;

   logic       vld_ff, vld_in;
   logic       end_ff, end_in;
   logic [8:0] ang_ff, ang_in;
   logic [8:0] aap_ff, aap_in;
   logic [8:0] ast_ff, ast_in;

   logic [17:0]           div_num;
   ssas_pkg::div_sel_type div_sel;
   logic [8:0]            div_quot;

   logic signed [11:0] head_x, step_x, low_x, high_x, sum_x, diff_x, ang_x, nlow_x;
   logic [7:0]  top_h;
   logic [9:0]  cost;
   logic [10:0] hi_tmp;
   logic [8:0]  mag_step;
   logic [9:0]  rem_inc;

   ssas_const_div u_div (
      .num  (div_num),
      .sel  (div_sel),
      .quot (div_quot)
   );

   assign head_x = {head_ff[10], head_ff};
   assign step_x = {{2{step_ff[9]}}, step_ff};
   assign low_x  = {{3{low_ff[8]}}, low_ff};
   assign high_x = {{3{high_ff[8]}}, high_ff};
   assign sum_x  = head_x + step_x;
   assign diff_x = head_x - low_x;
   assign nlow_x = 12'sd0 - low_x;

   assign top_h = (({1'b0, th_ff} + 9'(ssas_pkg::FIT_SPAN)) < 9'(ssas_pkg::HALF_TURN)) ?
                  (th_ff + 8'(ssas_pkg::FIT_SPAN)) : 8'(ssas_pkg::HALF_TURN);

   assign cost = (rem_ff == 9'd0) ? ({1'b0, sd_ff} + {6'd0, hd_ff}) :
                 10'(ssas_pkg::NO_FIT_COST);

   assign rem_inc  = {1'b0, rem_ff} + 10'd1;
   assign mag_step = step_ff[9] ? 9'(10'sd0 - step_ff) : step_ff[8:0];
   assign hi_tmp   = {3'd0, bh_ff} -
                     ((bh_ff == 8'(ssas_pkg::HALF_TURN)) ? {1'b0, bs_ff} : 11'd0);

   always_comb begin
      if (head_x < 12'sd0)
         ang_x = head_x + 12'sd400;
      else if (head_x >= 12'(ssas_pkg::GRADS_PER_TURN))
         ang_x = head_x - 12'sd400;
      else
         ang_x = head_x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssas_pkg::ST_IDLE;
         head_ff  <= 11'sd0;
         step_ff  <= 10'sd1;
         low_ff   <= -9'sd200;
         high_ff  <= 9'sd199;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         step_ff  <= step_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff  <= ret_in;
      ap_ff   <= ap_in;
      st_ff   <= st_in;
      fit_ff  <= fit_in;
      th_ff   <= th_in;
      ts_ff   <= ts_in;
      bs_ff   <= bs_in;
      bh_ff   <= bh_in;
      best_ff <= best_in;
      s_ff    <= s_in;
      h_ff    <= h_in;
      hd_ff   <= hd_in;
      sd_ff   <= sd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      end_ff  <= end_in;
      ang_ff  <= ang_in;
      aap_ff  <= aap_in;
      ast_ff  <= ast_in;
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      head_in  = head_ff;
      step_in  = step_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      ap_in    = ap_ff;
      st_in    = st_ff;
      fit_in   = fit_ff;
      th_in    = th_ff;
      ts_in    = ts_ff;
      bs_in    = bs_ff;
      bh_in    = bh_ff;
      best_in  = best_ff;
      s_in     = s_ff;
      h_in     = h_ff;
      hd_in    = hd_ff;
      sd_in    = sd_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      vld_in   = 1'b0;
      end_in   = end_ff;
      ang_in   = ang_ff;
      aap_in   = aap_ff;
      ast_in   = ast_ff;
      div_num  = 18'd0;
      div_sel  = ssas_pkg::DIV_BY_10;

      case (state_ff)
         ssas_pkg::ST_IDLE: begin
            if (start) begin
               ap_in  = (req_aperture > 9'(ssas_pkg::MAX_DEG)) ?
                        9'(ssas_pkg::MAX_DEG) : req_aperture;
               if (req_step > 9'(ssas_pkg::MAX_DEG))
                  st_in = 9'(ssas_pkg::MAX_DEG);
               else if (req_step == 9'd0)
                  st_in = 9'd1;
               else
                  st_in = req_step;
               fit_in   = req_fit_divisor;
               end_in   = 1'b0;
               state_in = (req_op == ssas_pkg::OP_ADVANCE) ?
                          ssas_pkg::ST_ADV_ADD : ssas_pkg::ST_CFG_TH;
            end
         end
         ssas_pkg::ST_CFG_TH: begin
            div_num  = {9'd0, ap_ff} * 18'd200 + 18'd180;
            div_sel  = ssas_pkg::DIV_BY_360;
            th_in    = div_quot[7:0];
            state_in = ssas_pkg::ST_CFG_TS;
         end
         ssas_pkg::ST_CFG_TS: begin
            div_num = {9'd0, st_ff} * 18'd400 + 18'd180;
            div_sel = ssas_pkg::DIV_BY_360;
            ts_in   = div_quot;
            bs_in   = {1'b0, div_quot};
            bh_in   = th_ff;
            if (fit_ff) begin
               rem_in   = {1'b0, th_ff};
               div_in   = {1'b0, div_quot};
               ret_in   = ssas_pkg::ST_CHK;
               state_in = ssas_pkg::ST_MOD;
            end else begin
               state_in = ssas_pkg::ST_SET;
            end
         end
         ssas_pkg::ST_MOD: begin
            // remainder by repeated subtraction, one subtract per cycle
            if ({1'b0, rem_ff} >= div_ff)
               rem_in = rem_ff - div_ff[8:0];
            else
               state_in = ret_ff;
         end
         ssas_pkg::ST_CHK: begin
            if (rem_ff == 9'd0) begin
               state_in = ssas_pkg::ST_SET;
            end else begin
               best_in  = 10'(ssas_pkg::NO_FIT_COST);
               s_in     = 10'd1;
               state_in = ssas_pkg::ST_NEXT_S;
            end
         end
         ssas_pkg::ST_NEXT_S: begin
            rem_in   = {1'b0, th_ff};
            div_in   = s_ff;
            sd_in    = (s_ff >= {1'b0, ts_ff}) ? 9'(s_ff - {1'b0, ts_ff}) :
                       9'({1'b0, ts_ff} - s_ff);
            h_in     = th_ff;
            hd_in    = 4'd0;
            ret_in   = ssas_pkg::ST_SRCH;
            state_in = ssas_pkg::ST_MOD;
         end
         ssas_pkg::ST_SRCH: begin
            if (cost < best_ff) begin
               best_in = cost;
               bs_in   = s_ff;
               bh_in   = h_ff;
            end
            if (h_ff == top_h) begin
               if (({1'b0, s_ff} + 11'd1) == {1'b0, ts_ff, 1'b0}) begin
                  state_in = ssas_pkg::ST_SET;
               end else begin
                  s_in     = s_ff + 10'd1;
                  state_in = ssas_pkg::ST_NEXT_S;
               end
            end else begin
               h_in   = h_ff + 8'd1;
               hd_in  = hd_ff + 4'd1;
               rem_in = (rem_inc == s_ff) ? 9'd0 : rem_inc[8:0];
            end
         end
         ssas_pkg::ST_SET: begin
            step_in  = bs_ff;
            low_in   = 9'sd0 - $signed({1'b0, bh_ff});
            high_in  = hi_tmp[8:0];
            state_in = ssas_pkg::ST_RANGE;
         end
         ssas_pkg::ST_RANGE: begin
            if (head_x < low_x || head_x > high_x) begin
               head_in  = 11'sd0;
               state_in = ssas_pkg::ST_FIN_AP;
            end else begin
               rem_in   = diff_x[8:0];
               div_in   = bs_ff;
               ret_in   = ssas_pkg::ST_HEAD;
               state_in = ssas_pkg::ST_MOD;
            end
         end
         ssas_pkg::ST_HEAD: begin
            if (rem_ff != 9'd0)
               head_in = 11'sd0;
            state_in = ssas_pkg::ST_FIN_AP;
         end
         ssas_pkg::ST_ADV_ADD: begin
            head_in  = head_ff + {step_ff[9], step_ff};
            state_in = ssas_pkg::ST_ADV_TEST;
         end
         ssas_pkg::ST_ADV_TEST: begin
            if (low_ff == -9'sd200) begin
               end_in = (sum_x > high_x);
               if (head_x > high_x)
                  head_in = {{2{low_ff[8]}}, low_ff};
            end else if (sum_x >= high_x || sum_x <= low_x) begin
               step_in = 10'sd0 - step_ff;
               end_in  = 1'b1;
            end
            state_in = ssas_pkg::ST_FIN_AP;
         end
         ssas_pkg::ST_FIN_AP: begin
            div_num  = {10'd0, nlow_x[7:0]} * 18'd18 + 18'd5;
            aap_in   = div_quot;
            state_in = ssas_pkg::ST_FIN_ST;
         end
         ssas_pkg::ST_FIN_ST: begin
            div_num  = {9'd0, mag_step} * 18'd9 + 18'd5;
            ast_in   = div_quot;
            ang_in   = ang_x[8:0];
            vld_in   = 1'b1;
            state_in = ssas_pkg::ST_IDLE;
         end
         default: begin
            state_in = ssas_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy                = (state_ff != ssas_pkg::ST_IDLE);
   assign rsp_valid           = vld_ff;
   assign rsp_angle_grad      = ang_ff;
   assign rsp_end_of_turn     = end_ff;
   assign rsp_actual_aperture = aap_ff;
   assign rsp_actual_step     = ast_ff;

endmodule
